// ----- design/contiguous_frame_allocator_top_defines.svh -----
// Assertion macros for the contiguous frame allocator.
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CFA_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CFA_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define CFA_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)
`define CFA_ASSERT_NXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

// ----- design/cfa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared constants and types of the contiguous frame allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;
    localparam int MAX_FRAMES_DEF = 16384;
    localparam int FRAME_W = 20;
    localparam int COUNT_W = 15;
    localparam int FRAMES_PER_WORD = 16;
    localparam int WORD_W = 2 * FRAMES_PER_WORD;

    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_ALLOC  = 2'd1;
    localparam logic [1:0] ST_HEAD   = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    localparam logic [2:0] RES_OK        = 3'd0;
    localparam logic [2:0] RES_NO_SPACE  = 3'd1;
    localparam logic [2:0] RES_NOT_HEAD  = 3'd2;
    localparam logic [2:0] RES_NOT_FREE  = 3'd3;
    localparam logic [2:0] RES_BAD_RANGE = 3'd4;

    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_MARK    = 2'd2;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;
endpackage

// ----- design/contiguous_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_top
// First-fit allocator of contiguous frame runs over a 2-bit state memory.
// ----------------------------------------------------------------------------
// Input channel: i_valid/o_stall with func, frame and count; output channel:
// o_valid/i_stall with frame_out and status, one result per item. An APB
// port writes base_frame (0x0) and frame_count (0x4).
// One item at a time, one frame at a time, over a RAM of 16 frames per word.
// A rejected request gets its result in the cycle after the transfer. An
// allocate scans for a fit, then writes the run; a mark checks up to count
// frames, then writes them; a release frees the head and the allocated
// frames behind it up to the pool end, and refuses a frame that is no head.
// The next item is taken once the result has left the output register.
// After reset a clearing pass writes every RAM word free, one word a cycle,
// while o_stall stays high; APB writes work throughout. A finished result
// sits in an output register while i_stall is high.
// ----------------------------------------------------------------------------
`include "contiguous_frame_allocator_top_defines.svh"
module contiguous_frame_allocator_top #(
    parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_func,
    input  logic [cfa_pkg::FRAME_W-1:0]  i_frame,
    input  logic [cfa_pkg::COUNT_W-1:0]  i_count,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [cfa_pkg::FRAME_W-1:0]  o_frame_out,
    output logic [2:0]                   o_status
);
    import cfa_pkg::*;

    localparam int DEPTH = (MAX_FRAMES + FRAMES_PER_WORD - 1) / FRAMES_PER_WORD;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(MAX_FRAMES + FRAMES_PER_WORD);
    localparam int IW = ((FW > COUNT_W) ? FW : COUNT_W) + 1;
    localparam int SW = $clog2(FRAMES_PER_WORD);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_WR    = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [FRAME_W-1:0]    r_base;
    logic [COUNT_W-1:0]    r_fcount;
    logic [1:0]            r_func;
    logic [COUNT_W-1:0]    r_cnt;
    logic [IW-1:0]         r_cur, r_start, r_run, r_end;
    logic                  r_wpass;
    logic [FRAME_W-1:0]    r_fout;
    logic [2:0]            r_status;
    logic                  r_ovalid;
    logic [AW-1:0]         r_clr;

    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [WORD_W-1:0]     ram_wdata, ram_rdata;

    cfa_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    logic               apb_wr;
    logic [IW-1:0]      pool_n;
    logic [1:0]         cur_st;
    logic [SW-1:0]      slot;
    logic [FRAME_W:0]   rel_full;
    logic [IW:0]        mark_end;
    logic [1:0]         new_st;
    logic               mark_bad;
    logic               early;
    logic               run_hit;
    logic               chk_done;
    logic               chk_write;
    logic               wr_last;

    assign apb_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COUNT) ? {17'd0, r_fcount} : {12'd0, r_base};

    assign pool_n = (32'(r_fcount) > 32'(MAX_FRAMES)) ? IW'(MAX_FRAMES) : IW'(r_fcount);
    assign slot = r_cur[SW-1:0];
    assign cur_st = ram_rdata[2*slot +: 2];
    assign rel_full = {1'b0, i_frame} - {1'b0, r_base};
    assign mark_end = (IW+1)'(rel_full[FRAME_W-1:0]) + (IW+1)'(i_count);
    assign mark_bad = rel_full[FRAME_W] ||
                      (FRAME_W+1)'(mark_end) > (FRAME_W+1)'(pool_n) ||
                      rel_full > (FRAME_W+1)'(pool_n) ||
                      (i_count != '0 && rel_full >= (FRAME_W+1)'(pool_n));

    always_comb begin
        unique case (i_func)
            FN_ALLOC:   early = (i_count == '0) || (IW'(i_count) > pool_n);
            FN_RELEASE: early = rel_full[FRAME_W] || (FRAME_W+1)'(pool_n) <= rel_full;
            FN_MARK:    early = mark_bad || (i_count == '0);
            default:    early = 1'b1;
        endcase
    end

    assign run_hit = (cur_st == ST_FREE) && (r_run + 1'b1 == IW'(r_cnt));
    assign wr_last = (r_func == FN_RELEASE) ? (r_cur + 1'b1 >= pool_n) :
                                              (r_cur + 1'b1 == r_end);

    always_comb begin
        chk_done = 1'b0;
        chk_write = 1'b0;
        if (r_func == FN_ALLOC && !r_wpass) begin
            chk_done = !run_hit && (r_cur + 1'b1 >= pool_n);
        end else if (r_func == FN_MARK && !r_wpass) begin
            chk_done = (cur_st != ST_FREE);
        end else if (r_func == FN_RELEASE) begin
            chk_done = (r_cur == r_start) ? (cur_st != ST_HEAD) : (cur_st != ST_ALLOC);
            chk_write = !chk_done;
        end else begin
            chk_write = 1'b1;
        end
    end

    always_comb begin
        if (r_func == FN_RELEASE) begin
            new_st = ST_FREE;
        end else if (r_func == FN_MARK) begin
            new_st = ST_CLOSED;
        end else begin
            new_st = (r_cur == r_start) ? ST_HEAD : ST_ALLOC;
        end
    end

    always_comb begin
        ram_we = 1'b0;
        ram_wdata = ram_rdata;
        ram_addr = r_cur[SW +: AW];
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
            ram_wdata = '0;
            ram_addr = r_clr;
        end else if (r_state == S_WR) begin
            ram_we = 1'b1;
            ram_wdata[2*slot +: 2] = new_st;
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_frame_out = r_fout;
    assign o_status = r_status;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_valid && !o_stall && !early) n_state = S_RD;
            S_RD:    n_state = S_CHK;
            S_CHK:   n_state = chk_done ? S_DONE : (chk_write ? S_WR : S_RD);
            S_WR:    n_state = wr_last ? S_DONE : S_WAIT;
            S_WAIT:  n_state = S_RD;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_base   <= '0;
            r_fcount <= COUNT_W'(16384);
        end else begin
            if (apb_wr) begin
                if (paddr[2] == REG_BASE) r_base <= pwdata[FRAME_W-1:0];
                else r_fcount <= pwdata[COUNT_W-1:0];
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_func <= i_func;
                        r_cnt <= i_count;
                        r_run <= '0;
                        r_wpass <= 1'b0;
                        r_fout <= '0;
                        if (i_func == FN_ALLOC) begin
                            r_cur <= '0;
                            r_start <= '0;
                            if (i_count == '0) begin
                                r_status <= RES_BAD_RANGE;
                                r_ovalid <= 1'b1;
                            end else if (IW'(i_count) > pool_n) begin
                                r_status <= RES_NO_SPACE;
                                r_ovalid <= 1'b1;
                            end
                        end else if (i_func == FN_RELEASE) begin
                            r_cur <= IW'(rel_full[FRAME_W-1:0]);
                            r_start <= IW'(rel_full[FRAME_W-1:0]);
                            if (early) begin
                                r_status <= RES_BAD_RANGE;
                                r_ovalid <= 1'b1;
                            end
                        end else if (i_func == FN_MARK) begin
                            r_cur <= IW'(rel_full[FRAME_W-1:0]);
                            r_start <= IW'(rel_full[FRAME_W-1:0]);
                            r_end <= IW'(mark_end);
                            if (mark_bad) begin
                                r_status <= RES_BAD_RANGE;
                                r_ovalid <= 1'b1;
                            end else if (i_count == '0) begin
                                r_status <= RES_OK;
                                r_ovalid <= 1'b1;
                            end
                        end else begin
                            r_status <= RES_BAD_RANGE;
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                S_RD: ;
                S_CHK: begin
                    if (r_func == FN_ALLOC && !r_wpass) begin
                        if (run_hit) begin
                            r_wpass <= 1'b1;
                            r_cur <= r_start;
                            r_end <= r_cur + 1'b1;
                        end else begin
                            r_cur <= r_cur + 1'b1;
                            if (cur_st == ST_FREE) begin
                                r_run <= r_run + 1'b1;
                            end else begin
                                r_run <= '0;
                                r_start <= r_cur + 1'b1;
                            end
                            if (chk_done) r_status <= RES_NO_SPACE;
                        end
                    end else if (r_func == FN_MARK && !r_wpass) begin
                        if (chk_done) begin
                            r_status <= RES_NOT_FREE;
                        end else if (r_cur + 1'b1 == r_end) begin
                            r_wpass <= 1'b1;
                            r_cur <= r_start;
                        end else begin
                            r_cur <= r_cur + 1'b1;
                        end
                    end else if (r_func == FN_RELEASE && chk_done) begin
                        r_status <= (r_cur == r_start) ? RES_NOT_HEAD : RES_OK;
                    end
                end
                S_WR: begin
                    r_cur <= r_cur + 1'b1;
                    if (wr_last) begin
                        r_status <= RES_OK;
                        if (r_func == FN_ALLOC) r_fout <= FRAME_W'(r_start) + r_base;
                    end
                end
                S_WAIT: ;
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    `CFA_ASSERT_NXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, o_valid, "result lost")
    `CFA_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_stall, "accept while busy")
    `CFA_ASSERT_IMP(a_fout_zero, i_clk, i_rst_n, o_valid && o_status != RES_OK,
        o_frame_out == '0, "frame_out not zero on failure")
endmodule

// ----- design/cfa_ram.sv -----
// ----------------------------------------------------------------------------
// cfa_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- test/tb_contiguous_frame_allocator_top.sv -----
// ----------------------------------------------------------------------------
// tb_contiguous_frame_allocator_top
// Self-checking bench for the first-fit frame allocator.
// ----------------------------------------------------------------------------
// A directed table covers the reset pool, field extremes, every function and
// every status code. It is followed by random phases over several pool
// settings. Each phase mostly allocates, also releases the runs it got and
// releases and marks random frames, with some malformed requests mixed in but
// in the last phase. An in-bench model of the frame states predicts every
// transfer. The sender works in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_contiguous_frame_allocator_top;
    import cfa_pkg::*;

    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int NFR = MAX_FRAMES_DEF;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_func;
    logic [FRAME_W-1:0]  i_frame;
    logic [COUNT_W-1:0]  i_count;
    logic                o_valid;
    logic                i_stall;
    logic [FRAME_W-1:0]  o_frame_out;
    logic [2:0]          o_status;

    contiguous_frame_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_frame(i_frame), .i_count(i_count),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_frame_out(o_frame_out), .o_status(o_status)
    );

    typedef struct packed {
        logic [FRAME_W-1:0] frame_out;
        logic [2:0]         status;
    } t_alloc_result;

    typedef struct {
        logic [1:0]         func;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
        bit                 typed;
        t_alloc_result      result;
    } t_request_row;

    logic [1:0]         frame_state [NFR];
    logic [FRAME_W-1:0] pool_base;
    logic [COUNT_W-1:0] pool_count;
    t_alloc_result      pending_results [$];
    logic [FRAME_W-1:0] live_heads [$];
    int                 errors;
    int                 stall_pct;
    int                 gap_pct;

    always #5 i_clk = ~i_clk;

    function automatic int pool_frames();
        return (pool_count > NFR) ? NFR : int'(pool_count);
    endfunction

    function automatic t_alloc_result model_request(logic [1:0] fn,
                                                    logic [FRAME_W-1:0] frm,
                                                    logic [COUNT_W-1:0] cnt);
        t_alloc_result r;
        int n, run, start, rel;
        n = pool_frames();
        r.frame_out = '0;
        r.status = RES_OK;
        if (fn == FN_ALLOC) begin
            run = 0;
            start = 0;
            if (cnt == 0) begin
                r.status = RES_BAD_RANGE;
                return r;
            end
            for (int i = 0; i < n; i++) begin
                if (frame_state[i] == ST_FREE) begin
                    run++;
                end else begin
                    run = 0;
                    start = i + 1;
                end
                if (run == cnt) break;
            end
            if (run != cnt) begin
                r.status = RES_NO_SPACE;
                return r;
            end
            frame_state[start] = ST_HEAD;
            for (int i = 1; i < cnt; i++) frame_state[start + i] = ST_ALLOC;
            r.frame_out = FRAME_W'(start) + pool_base;
        end else if (fn == FN_RELEASE) begin
            rel = int'(frm) - int'(pool_base);
            if (frm < pool_base || rel >= n) begin
                r.status = RES_BAD_RANGE;
            end else if (frame_state[rel] != ST_HEAD) begin
                r.status = RES_NOT_HEAD;
            end else begin
                frame_state[rel] = ST_FREE;
                for (int c = rel + 1; c < n && frame_state[c] == ST_ALLOC; c++)
                    frame_state[c] = ST_FREE;
            end
        end else if (fn == FN_MARK) begin
            rel = int'(frm) - int'(pool_base);
            if (frm < pool_base || rel + int'(cnt) > n || (cnt != 0 && rel >= n)) begin
                r.status = RES_BAD_RANGE;
                return r;
            end
            for (int i = 0; i < cnt; i++)
                if (frame_state[rel + i] != ST_FREE) r.status = RES_NOT_FREE;
            if (r.status == RES_OK)
                for (int i = 0; i < cnt; i++) frame_state[rel + i] = ST_CLOSED;
        end else begin
            r.status = RES_BAD_RANGE;
        end
        return r;
    endfunction

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_pool(logic [FRAME_W-1:0] b, logic [COUNT_W-1:0] c);
        drain();
        reg_write({REG_BASE, 2'b00}, 32'(b));
        reg_write({REG_COUNT, 2'b00}, 32'(c));
        pool_base = b;
        pool_count = c;
        live_heads.delete();
    endtask

    // hold the payload until the transfer, then predict it
    task automatic send(logic [1:0] fn, logic [FRAME_W-1:0] frm,
                        logic [COUNT_W-1:0] cnt, bit typed, t_alloc_result typed_res);
        t_alloc_result r;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_frame <= frm;
        i_count <= cnt;
        do @(posedge i_clk); while (o_stall);
        r = model_request(fn, frm, cnt);
        if (fn == FN_ALLOC && r.status == RES_OK) live_heads.push_back(r.frame_out);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic random_request(int maxrun, bit noise_ok);
        int n, sel, idx;
        t_alloc_result none;
        n = pool_frames();
        none = '0;
        sel = $urandom_range(0, 99);
        if (noise_ok && sel < 12) begin
            send(2'($urandom), 20'($urandom), 15'($urandom), 1'b0, none);
        end else if (sel < 55 || n == 0) begin
            send(FN_ALLOC, 20'($urandom), 15'($urandom_range(1, maxrun)), 1'b0, none);
        end else if (sel < 85 && live_heads.size() != 0) begin
            idx = $urandom_range(0, live_heads.size() - 1);
            send(FN_RELEASE, live_heads[idx], 15'($urandom), 1'b0, none);
            live_heads.delete(idx);
        end else if (sel < 90) begin
            send(FN_RELEASE, pool_base + 20'($urandom_range(0, n - 1)), 15'($urandom),
                 1'b0, none);
        end else begin
            send(FN_MARK, pool_base + 20'($urandom_range(0, n - 1)),
                 15'($urandom_range(0, 3)), 1'b0, none);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer frame_out=%h status=%0d",
                         $time, o_frame_out, o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_frame_out !== want.frame_out) begin
                    $display("%0t: frame_out expected %h actual %h",
                             $time, want.frame_out, o_frame_out);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        #40000000;
        $display("tb_contiguous_frame_allocator_top: errors");
        $finish;
    end

    initial begin
        t_request_row dir_rows [$];
        t_alloc_result none;
        logic [FRAME_W-1:0] bases [7];
        logic [COUNT_W-1:0] counts [7];
        int items [7];
        none = '0;
        i_clk = 1'b0;
        errors = 0;
        stall_pct = 30;
        gap_pct = 30;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_func <= FN_ALLOC;
        i_frame <= '0;
        i_count <= '0;
        for (int i = 0; i < NFR; i++) frame_state[i] = ST_FREE;
        pool_base = '0;
        pool_count = 15'(NFR);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = '{
            '{FN_ALLOC,   20'h0,     15'd0,     1, '{20'h0, RES_BAD_RANGE}},
            '{FN_ALLOC,   20'hfffff, 15'd1,     1, '{20'h0, RES_OK}},
            '{FN_ALLOC,   20'h0,     15'd3,     1, '{20'h1, RES_OK}},
            '{FN_RELEASE, 20'h2,     15'h7fff,  1, '{20'h0, RES_NOT_HEAD}},
            '{FN_RELEASE, 20'h0,     15'd0,     1, '{20'h0, RES_OK}},
            '{FN_RELEASE, 20'h1,     15'd0,     1, '{20'h0, RES_OK}},
            '{FN_RELEASE, 20'h1,     15'd0,     1, '{20'h0, RES_NOT_HEAD}},
            '{FN_ALLOC,   20'h0,     15'd2,     0, none},
            '{FN_MARK,    20'd100,   15'd4,     1, '{20'h0, RES_OK}},
            '{FN_MARK,    20'd101,   15'd1,     1, '{20'h0, RES_NOT_FREE}},
            '{FN_RELEASE, 20'd100,   15'd0,     1, '{20'h0, RES_NOT_HEAD}},
            '{FN_MARK,    20'd16384, 15'd0,     1, '{20'h0, RES_OK}},
            '{FN_MARK,    20'd16383, 15'd2,     1, '{20'h0, RES_BAD_RANGE}},
            '{FN_MARK,    20'd50,    15'd0,     0, none},
            '{FN_UNUSED,  20'hfffff, 15'h7fff,  1, '{20'h0, RES_BAD_RANGE}},
            '{FN_RELEASE, 20'hfffff, 15'd0,     1, '{20'h0, RES_BAD_RANGE}},
            '{FN_MARK,    20'hfffff, 15'h7fff,  1, '{20'h0, RES_BAD_RANGE}},
            '{FN_ALLOC,   20'h0,     15'd16384, 1, '{20'h0, RES_NO_SPACE}},
            '{FN_ALLOC,   20'h0,     15'h7fff,  1, '{20'h0, RES_NO_SPACE}},
            '{FN_ALLOC,   20'h0,     15'd5,     0, none}
        };
        foreach (dir_rows[k])
            send(dir_rows[k].func, dir_rows[k].frame, dir_rows[k].count,
                 dir_rows[k].typed, dir_rows[k].result);

        bases  = '{20'hffff0, 20'd0, 20'd1000, 20'h12345, 20'd7, 20'hfffff, 20'd0};
        counts = '{15'd64, 15'd4, 15'd128, 15'd0, 15'd256, 15'd32, 15'h7fff};
        items  = '{140, 90, 150, 20, 150, 140, 20};
        for (int p = 0; p < 7; p++) begin
            set_pool(bases[p], counts[p]);
            stall_pct = (p % 3 == 0) ? 0 : 10 + 15 * p;
            gap_pct = (p == 1) ? 0 : 10 + 10 * (p % 4);
            for (int k = 0; k < items[p]; k++) begin
                if (k == items[p] / 2) begin
                    i_valid <= 1'b0;
                    do @(posedge i_clk); while (pending_results.size() != 0);
                end
                if (p == 6) random_request(8, 1'b0);
                else random_request((pool_frames() > 8) ? pool_frames() / 4 : 4, 1'b1);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_contiguous_frame_allocator_top: clean");
        end else begin
            $display("tb_contiguous_frame_allocator_top: errors");
        end
        $finish;
    end
endmodule
